// ----- rtl/upd_pkg.sv -----
// Shared types, byte codes and per-byte decode functions for the URL path decoder.
// No dependencies; imported by every module of the block.
package upd_pkg;

    // Result burst depth: one input byte yields at most four results.
    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned IDX_W     = $clog2(BURST_MAX);
    localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        V_OK     = 2'd0,
        V_EMPTY  = 2'd1,
        V_REJECT = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX1 = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } t_seg;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held;
        logic       in_query;
        logic       at_start;
        t_seg       seg;
        logic       rejected;
        logic       any_emitted;
    } t_dec_state;

    localparam t_dec_state DEC_RESET = '{
        phase: PH_IDLE, held: 8'h00, in_query: 1'b0, at_start: 1'b1,
        seg: SEG_EMPTY, rejected: 1'b0, any_emitted: 1'b0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        t_verdict   verdict;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        t_result [BURST_MAX-1:0]    slot;
    } t_burst;

    // Working value threaded through the steps of one byte.
    typedef struct packed {
        t_dec_state st;
        t_burst     bu;
    } t_step;

    function automatic logic upd_is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] upd_hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)      v = c - 8'h30;
        else if (c >= 8'h61) v = c - 8'h57;
        else                 v = c - 8'h37;
        return v[3:0];
    endfunction

    function automatic t_step upd_push(input t_step x, input t_result r);
        t_step y;
        y = x;
        y.bu.slot[y.bu.cnt[IDX_W-1:0]] = r;
        y.bu.cnt = y.bu.cnt + CNT_W'(1);
        return y;
    endfunction

    // One decoded byte into the path stage: slash stripping, segment tracking.
    function automatic t_step upd_emit(input t_step x, input logic [7:0] c);
        t_step   y;
        t_result r;
        y = x;
        r = '{kind: KIND_PATH, path_byte: c, verdict: V_OK, last: 1'b0};
        if (!(y.st.at_start && c == CH_SLASH)) begin
            y.st.at_start    = 1'b0;
            y.st.any_emitted = 1'b1;
            if (c == CH_NUL || c == CH_BSL) y.st.rejected = 1'b1;
            if (c == CH_SLASH) begin
                if (y.st.seg == SEG_DOTDOT) y.st.rejected = 1'b1;
                y.st.seg = SEG_EMPTY;
            end else if (c == CH_DOT) begin
                unique case (y.st.seg)
                    SEG_EMPTY:  y.st.seg = SEG_DOT;
                    SEG_DOT:    y.st.seg = SEG_DOTDOT;
                    SEG_DOTDOT: y.st.seg = SEG_OTHER;
                    SEG_OTHER:  y.st.seg = SEG_OTHER;
                endcase
            end else begin
                y.st.seg = SEG_OTHER;
            end
            y = upd_push(y, r);
        end
        return y;
    endfunction

    // Raw byte with no escape pending.
    function automatic t_step upd_raw_idle(input t_step x, input logic [7:0] b);
        t_step y;
        y = x;
        if (b == CH_QM || b == CH_HASH) y.st.in_query = 1'b1;
        else if (b == CH_PCT)           y.st.phase = PH_PCT;
        else                            y = upd_emit(y, b);
        return y;
    endfunction

endpackage

// ----- rtl/upd_intf.sv -----
// Valid/ready beat channels for target bytes in and decoded results out.
// No dependencies.
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] target_byte;
    logic       end_of_target;

    modport source (output valid, target_byte, end_of_target, input ready);
    modport sink   (input valid, target_byte, end_of_target, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] path_byte;
    logic [1:0] verdict;
    logic       last;

    modport source (output valid, kind, path_byte, verdict, last, input ready);
    modport sink   (input valid, kind, path_byte, verdict, last, output ready);
endinterface

// ----- rtl/url_path_decode_sanitize_top.sv -----
// Top level of the streaming URL path decoder with traversal check.
// Depends on upd_pkg, upd_intf, upd_core and upd_serializer.
// Path: a byte passes the input register of upd_core and then the serializer buffer
//   before its first result beat is offered.
// Throughput: one byte per cycle while each byte yields at most one beat and the output
//   is ready; a byte yielding more beats (up to 4) holds the next burst until they leave.
// Reset: synchronous, active low; decoder state returns to start-of-target, buffer empties.
module url_path_decode_sanitize_top import upd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upd_in_if.sink    i_tgt,
    upd_out_if.source o_res
);

    // Burst hand-off between the decode stage and the output buffer.
    logic   burst_vld;
    t_burst burst;
    logic   burst_take;

    // Decode stage: input register, escape/segment state, up to 4 results per byte.
    upd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tgt        (i_tgt),
        .o_burst_vld  (burst_vld),
        .o_burst      (burst),
        .i_burst_take (burst_take)
    );

    // Output buffer: drains a burst one beat per cycle while the sink is ready, takes the next burst
    // in the cycle the last pending beat leaves.
    upd_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_burst_vld  (burst_vld),
        .i_burst      (burst),
        .o_burst_take (burst_take),
        .o_res        (o_res)
    );

endmodule

// ----- rtl/upd_core.sv -----
// Input register and single-pass decode of one target byte into a result burst.
// Depends on upd_pkg and upd_in_if.
module upd_core import upd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upd_in_if.sink      i_tgt,
    output logic        o_burst_vld,
    output t_burst      o_burst,
    input  logic        i_burst_take
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_dec_state r_st;
    t_step      c_step;
    logic       in_fire;

    assign i_tgt.ready = !r_in_vld || i_burst_take;
    assign in_fire     = i_tgt.valid && i_tgt.ready;

    always_comb begin
        c_step.st = r_st;
        c_step.bu = '0;
        if (!c_step.st.in_query) begin
            unique case (c_step.st.phase)
                PH_IDLE: begin
                    c_step = upd_raw_idle(c_step, r_in_byte);
                end
                PH_PCT: begin
                    if (upd_is_hex(r_in_byte)) begin
                        c_step.st.held  = r_in_byte;
                        c_step.st.phase = PH_HEX1;
                    end else begin
                        c_step.st.phase = PH_IDLE;
                        c_step = upd_emit(c_step, CH_PCT);
                        c_step = upd_raw_idle(c_step, r_in_byte);
                    end
                end
                default: begin
                    c_step.st.phase = PH_IDLE;
                    if (upd_is_hex(r_in_byte)) begin
                        c_step = upd_emit(c_step,
                            {upd_hex_val(c_step.st.held), upd_hex_val(r_in_byte)});
                    end else begin
                        c_step = upd_emit(c_step, CH_PCT);
                        c_step = upd_emit(c_step, c_step.st.held);
                        c_step = upd_raw_idle(c_step, r_in_byte);
                    end
                end
            endcase
        end
        if (r_in_end) begin
            // escape cut off by the end goes out raw
            if (c_step.st.phase != PH_IDLE) c_step = upd_emit(c_step, CH_PCT);
            if (c_step.st.phase == PH_HEX1) c_step = upd_emit(c_step, c_step.st.held);
            if (c_step.st.seg == SEG_DOTDOT) c_step.st.rejected = 1'b1;
            priority if (!c_step.st.any_emitted) begin
                c_step = upd_push(c_step, '{kind: KIND_VERDICT, path_byte: 8'h00,
                                            verdict: V_EMPTY, last: 1'b1});
            end else if (c_step.st.rejected) begin
                c_step = upd_push(c_step, '{kind: KIND_VERDICT, path_byte: 8'h00,
                                            verdict: V_REJECT, last: 1'b1});
            end else begin
                c_step = upd_push(c_step, '{kind: KIND_VERDICT, path_byte: 8'h00,
                                            verdict: V_OK, last: 1'b1});
            end
            c_step.st = DEC_RESET;
        end
    end

    assign o_burst_vld = r_in_vld;
    assign o_burst     = c_step.bu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= DEC_RESET;
        end else begin
            if (in_fire)           r_in_vld <= 1'b1;
            else if (i_burst_take) r_in_vld <= 1'b0;
            if (r_in_vld && i_burst_take) r_st <= c_step.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_tgt.target_byte;
            r_in_end  <= i_tgt.end_of_target;
        end
    end

    ap_end_has_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_in_end |-> o_burst.cnt != '0)
        else $error("end byte produced no verdict");

    ap_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst.cnt <= CNT_W'(BURST_MAX))
        else $error("burst overflow");

    ap_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && i_burst_take && r_in_end |=> r_st.at_start && !r_st.in_query &&
        r_st.phase == PH_IDLE && !r_st.any_emitted)
        else $error("state not cleared after end of target");

endmodule

// ----- rtl/upd_serializer.sv -----
// Burst buffer that hands results out one beat per cycle while the sink is ready.
// Depends on upd_pkg and upd_out_if.
module upd_serializer import upd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_burst_vld,
    input  t_burst      i_burst,
    output logic        o_burst_take,
    upd_out_if.source   o_res
);

    t_result [BURST_MAX-1:0] r_buf;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_idx;
    t_result                 c_head;
    logic                    out_fire;
    logic                    buf_free;
    logic                    load;

    assign c_head          = r_buf[r_idx];
    assign o_res.valid     = r_cnt != '0;
    assign o_res.kind      = c_head.kind;
    assign o_res.path_byte = c_head.path_byte;
    assign o_res.verdict   = c_head.verdict;
    assign o_res.last      = c_head.last;

    assign out_fire     = o_res.valid && o_res.ready;
    assign buf_free     = r_cnt == '0 || (out_fire && r_cnt == CNT_W'(1));
    // empty bursts pass straight through
    assign o_burst_take = i_burst_vld && (i_burst.cnt == '0 || buf_free);
    assign load         = o_burst_take && i_burst.cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_cnt <= i_burst.cnt;
            r_idx <= '0;
        end else if (out_fire) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_buf <= i_burst.slot;
    end

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BURST_MAX))
        else $error("buffer count out of range");

    ap_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_cnt == '0 || (out_fire && r_cnt == CNT_W'(1)))
        else $error("burst loaded over pending results");

    ap_last_is_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last |-> o_res.kind == KIND_VERDICT &&
        r_cnt == CNT_W'(1))
        else $error("last beat is not the closing verdict");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for url_path_decode_sanitize_top: directed and random request targets
// with a scoreboard that predicts every result beat. Needs upd_pkg, upd_intf and the RTL.
module tb_top import upd_pkg::*; ();

    // Predicts the decoded path beats and the verdict of each target, then checks
    // the result beats of the block against them in order.
    class path_decode_predictor;
        t_phase      esc;
        logic [7:0]  held;
        bit          in_query;
        bit          at_start;
        t_seg        seg;
        bit          rejected;
        bit          any_emitted;
        t_result     expected_beats[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned verdicts_seen[3];

        function new();
            clear_target();
        endfunction

        function void clear_target();
            esc         = PH_IDLE;
            held        = 8'h00;
            in_query    = 1'b0;
            at_start    = 1'b1;
            seg         = SEG_EMPTY;
            rejected    = 1'b0;
            any_emitted = 1'b0;
        endfunction

        static function bit is_hex_digit(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        static function logic [3:0] nibble_of(logic [7:0] c);
            logic [7:0] v;
            if (c >= "0" && c <= "9") v = c - "0";
            else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
            else v = c - "A" + 8'd10;
            return v[3:0];
        endfunction

        // Decoded byte into the path: drop leading slashes, track the segment.
        function void push_decoded(logic [7:0] c);
            t_result r;
            if (at_start && c == CH_SLASH) return;
            at_start    = 1'b0;
            any_emitted = 1'b1;
            if (c == CH_NUL || c == CH_BSL) rejected = 1'b1;
            if (c == CH_SLASH) begin
                if (seg == SEG_DOTDOT) rejected = 1'b1;
                seg = SEG_EMPTY;
            end else if (c == CH_DOT) begin
                if (seg != SEG_OTHER) seg = t_seg'(seg + 2'd1);
            end else begin
                seg = SEG_OTHER;
            end
            r = '{kind: KIND_PATH, path_byte: c, verdict: V_OK, last: 1'b0};
            expected_beats.insert(expected_beats.size(), r);
        endfunction

        function void take_raw(logic [7:0] b);
            if (b == CH_QM || b == CH_HASH) in_query = 1'b1;
            else if (b == CH_PCT) esc = PH_PCT;
            else push_decoded(b);
        endfunction

        // Returns 1 when the byte was not swallowed by a query part.
        function bit note_byte(logic [7:0] b, logic eot);
            bit       used;
            t_verdict v;
            t_result  r;
            used = !in_query;
            if (!in_query) begin
                case (esc)
                    PH_IDLE: begin
                        take_raw(b);
                    end
                    PH_PCT: begin
                        if (is_hex_digit(b)) begin
                            held = b;
                            esc  = PH_HEX1;
                        end else begin
                            esc = PH_IDLE;
                            push_decoded(CH_PCT);
                            take_raw(b);
                        end
                    end
                    default: begin
                        esc = PH_IDLE;
                        if (is_hex_digit(b)) begin
                            push_decoded({nibble_of(held), nibble_of(b)});
                        end else begin
                            push_decoded(CH_PCT);
                            push_decoded(held);
                            take_raw(b);
                        end
                    end
                endcase
            end
            if (eot) begin
                // escape cut off by the end goes out raw
                if (esc != PH_IDLE) push_decoded(CH_PCT);
                if (esc == PH_HEX1) push_decoded(held);
                if (seg == SEG_DOTDOT) rejected = 1'b1;
                if (!any_emitted) v = V_EMPTY;
                else if (rejected) v = V_REJECT;
                else v = V_OK;
                r = '{kind: KIND_VERDICT, path_byte: 8'h00, verdict: v, last: 1'b1};
                expected_beats.insert(expected_beats.size(), r);
                clear_target();
            end
            return used;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH beat %0d: %s", $realtime, checked, what);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h verdict=%0d last=%0d",
                                          got.kind, got.path_byte, got.verdict, got.last));
                return;
            end
            want = expected_beats.pop_front();
            checked++;
            if (want.kind == KIND_VERDICT) verdicts_seen[want.verdict]++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind got %0d exp %0d", got.kind, want.kind));
            if (got.path_byte !== want.path_byte)
                report_mismatch($sformatf("path_byte got %02h exp %02h",
                                          got.path_byte, want.path_byte));
            if (got.verdict !== want.verdict)
                report_mismatch($sformatf("verdict got %0d exp %0d", got.verdict, want.verdict));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0d exp %0d", got.last, want.last));
        endtask
    endclass

    localparam int unsigned STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;

    upd_in_if  tgt_if ();
    upd_out_if res_if ();

    url_path_decode_sanitize_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tgt   (tgt_if),
        .o_res   (res_if)
    );

    path_decode_predictor path_model;
    logic [7:0]  tgt_bytes[$];
    bit          src_gaps;
    bit          snk_gaps;
    int unsigned live_beats;
    int unsigned sent_bytes;
    int unsigned targets_sent;
    int unsigned stall_cycles;
    t_result     res_beat;

    // 4 ns clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Source side helpers. Everything changes at the falling edge and the
    // handshake is judged at the rising edge.
    // ---------------------------------------------------------------------

    // One beat; an optional idle burst ahead of it. valid stays high between
    // back-to-back beats so it is never dropped and raised in the same step.
    task automatic send_beat(input logic [7:0] b, input logic eot);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            tgt_if.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        tgt_if.valid         = 1'b1;
        tgt_if.target_byte   = b;
        tgt_if.end_of_target = eot;
        do @(posedge clk); while (!tgt_if.ready);
        if (path_model.note_byte(b, eot)) live_beats++;
        sent_bytes++;
        if (eot) targets_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    endtask

    task automatic send_target();
        foreach (tgt_bytes[i]) send_beat(tgt_bytes[i], i == tgt_bytes.size() - 1);
    endtask

    // Hold the sender off until every predicted beat has come out.
    task automatic drain_results();
        tgt_if.valid = 1'b0;
        while (path_model.expected_beats.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        tgt_bytes.insert(tgt_bytes.size(), v);
    endfunction

    // Random target. Mostly path-like pieces with good and bad escapes; some
    // targets are pure noise, some are cut short mid-piece.
    task automatic build_random_target();
        int unsigned goal;
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  v;
        tgt_bytes.delete();
        goal = $urandom_range(1, 14);
        if ($urandom_range(0, 9) == 0) begin
            repeat (goal) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        while (tgt_bytes.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                add_byte(CH_SLASH);
            end else if (pick < 30) begin
                add_byte(CH_DOT);
            end else if (pick < 38) begin
                add_byte(CH_DOT);
                add_byte(CH_DOT);
            end else if (pick < 56) begin
                case ($urandom_range(0, 2))
                    0:       v = 8'($urandom_range(8'h61, 8'h7A));
                    1:       v = 8'($urandom_range(8'h41, 8'h5A));
                    default: v = 8'($urandom_range(8'h30, 8'h39));
                endcase
                add_byte(v);
            end else if (pick < 78) begin
                // well-formed escape, often of a byte the path check cares about
                case ($urandom_range(0, 9))
                    0:       v = CH_DOT;
                    1:       v = CH_SLASH;
                    2:       v = CH_NUL;
                    3:       v = CH_BSL;
                    4:       v = CH_QM;
                    5:       v = CH_HASH;
                    6:       v = CH_PCT;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                add_byte(CH_PCT);
                add_byte(hex_char(v[7:4], $urandom_range(0, 1)));
                add_byte(hex_char(v[3:0], $urandom_range(0, 1)));
            end else if (pick < 88) begin
                // broken escape: '%' [hex] then a non-hex byte
                add_byte(CH_PCT);
                if ($urandom_range(0, 1))
                    add_byte(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)));
                case ($urandom_range(0, 4))
                    0:       v = CH_PCT;
                    1:       v = CH_SLASH;
                    2:       v = CH_QM;
                    default: begin
                        do v = 8'($urandom_range(0, 255));
                        while (path_decode_predictor::is_hex_digit(v));
                    end
                endcase
                add_byte(v);
            end else if (pick < 97) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_byte($urandom_range(0, 1) ? CH_QM : CH_HASH);
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, tgt_bytes.size());
            while (tgt_bytes.size() > cut) void'(tgt_bytes.pop_back());
        end
    endtask

    // ---------------------------------------------------------------------
    // Sink side: ready in random runs, with random low bursts between them.
    // ---------------------------------------------------------------------
    initial begin
        int unsigned run;
        res_if.ready = 1'b1;
        forever begin
            if (snk_gaps && $urandom_range(0, 3) == 0) begin
                res_if.ready = 1'b0;
                run = $urandom_range(1, 10);
            end else begin
                res_if.ready = 1'b1;
                run = $urandom_range(1, 16);
            end
            repeat (run) @(negedge clk);
        end
    end

    // Result monitor: every accepted beat goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            res_beat.kind      = res_if.kind;
            res_beat.path_byte = res_if.path_byte;
            res_beat.verdict   = t_verdict'(res_if.verdict);
            res_beat.last      = res_if.last;
            path_model.check_result(res_beat);
        end
    end

    // Watchdog: too long without a beat on either side means the block hung.
    always @(posedge clk) begin
        if ((tgt_if.valid && tgt_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d beats still due",
                         $realtime, STALL_LIMIT, path_model.expected_beats.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        path_model           = new();
        rst_n                = 1'b0;
        tgt_if.valid         = 1'b0;
        tgt_if.target_byte   = 8'h00;
        tgt_if.end_of_target = 1'b0;
        src_gaps             = 1'b1;
        snk_gaps             = 1'b1;
        live_beats           = 0;
        sent_bytes           = 0;
        targets_sent         = 0;
        stall_cycles         = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed targets
        send_text("//a%41");    // leading slashes dropped, escape right at the end
        send_text("%4g");       // broken after one hex digit: '%', '4', 'g' raw
        send_text("%%3F");      // broken by a second '%', then a decoded '?'
        send_text("/..");       // dot-dot segment at the end
        send_text("a?b");       // query mark hides the rest
        send_text("%4");        // cut off with a digit held
        send_text("/");         // nothing left: empty path
        send_beat(8'hFF, 1'b0); // byte extremes, NUL rejects
        send_beat(CH_NUL, 1'b1);
        send_text("\\%");       // backslash, then a lone '%' cut off
        drain_results();

        // Random targets with idling on both sides
        while (sent_bytes < 280) begin
            build_random_target();
            send_target();
        end
        drain_results();
        while (sent_bytes < 320) begin
            build_random_target();
            send_target();
        end

        // Closing stretch at full rate
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        while (sent_bytes < 400) begin
            build_random_target();
            send_target();
        end
        tgt_if.valid = 1'b0;

        while (path_model.expected_beats.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d targets, %0d input bytes (%0d outside a query), %0d beats checked.",
                 targets_sent, sent_bytes, live_beats, path_model.checked);
        $display("Verdicts seen: ok %0d, empty %0d, rejected %0d.",
                 path_model.verdicts_seen[V_OK], path_model.verdicts_seen[V_EMPTY],
                 path_model.verdicts_seen[V_REJECT]);
        if (path_model.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
